FILE: hw/rtl/vmlf_pkg.sv
package vmlf_pkg;

  // address width default for the play position
  localparam int ADDR_BITS_DEF = 24;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 18;
  localparam int INDEX_W  = 24;
  localparam int LEVEL_W  = 17;
  localparam int STEP_W   = 21;
  localparam int ACTION_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TOTAL = 3'd4;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_MIX     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FADE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 18'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_UNITY = 17'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 17'd131071;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // latch the word, take gain * level
    logic mul_left;   // left magnitude * factor
    logic mul_right;  // right magnitude * factor, left mix
    logic wb;         // right mix, state update, output register
  } vmlf_cmd_t;

endpackage

FILE: hw/rtl/vmlf_ctrl.sv
module vmlf_ctrl
  import vmlf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output vmlf_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LEFT  = 2'd1;
  localparam logic [1:0] S_RIGHT = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LEFT;
        end
      end
      S_LEFT: begin
        cmd.mul_left = 1'b1;
        state_nxt    = S_RIGHT;
      end
      S_RIGHT: begin
        cmd.mul_right = 1'b1;
        state_nxt     = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          cmd.wb        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_LEFT)
    else $error("accepted word did not start the multiply sequence");

  a_valid_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_WB)
    else $error("result appeared without write-back");

  a_wb_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && out_valid_r && out_stall) |=> state_r == S_WB)
    else $error("write-back overran a held result");

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul_left, cmd.mul_right, cmd.wb}))
    else $error("more than one datapath command at once");

endmodule

FILE: hw/rtl/vmlf_datapath.sv
module vmlf_datapath
  import vmlf_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vmlf_cmd_t                    cmd,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [ACTION_W-1:0]          in_action,
  input  logic signed [SAMPLE_W-1:0]   in_acc_left,
  input  logic signed [SAMPLE_W-1:0]   in_acc_right,
  input  logic signed [SAMPLE_W-1:0]   in_voice_left,
  input  logic signed [SAMPLE_W-1:0]   in_voice_right,
  input  logic [LEVEL_W-1:0]           in_fade_target,
  input  logic signed [STEP_W-1:0]     in_fade_step,
  output logic signed [SAMPLE_W-1:0]   out_mix_left,
  output logic signed [SAMPLE_W-1:0]   out_mix_right,
  output logic [INDEX_W-1:0]           out_fetch_address,
  output logic                         out_voice_done
);

  localparam int CMP_W  = (ADDR_BITS > INDEX_W) ? ADDR_BITS : INDEX_W;
  localparam int OPA_W  = GAIN_W + 1;
  localparam int OPB_W  = LEVEL_W;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int SUM_W  = 23;

  // configuration
  logic [GAIN_W-1:0]  gain_r;
  logic [INDEX_W-1:0] loop_start_r, loop_end_r, sample_total_r;
  logic               loop_enable_r;

  // voice state
  logic [ADDR_BITS-1:0]     position_r, position_nxt;
  logic [LEVEL_W-1:0]       level_r, level_nxt;
  logic signed [STEP_W-1:0] slope_r, slope_nxt;
  logic [LEVEL_W-1:0]       goal_r, goal_nxt;
  logic                     finished_r, finished_nxt;

  // latched word
  logic [ACTION_W-1:0]        action_r;
  logic signed [SAMPLE_W-1:0] acc_l_r, acc_r_r, voice_l_r, voice_r_r;
  logic [LEVEL_W-1:0]         target_r;
  logic signed [STEP_W-1:0]   step_r;

  logic [OPA_W-1:0]         factor_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [SAMPLE_W-1:0] mix_l_r;

  logic [OPA_W-1:0]  op_a;
  logic [OPB_W-1:0]  op_b;
  logic [PROD_W-1:0] prod;
  logic [SAMPLE_W-1:0] mag_l, mag_r;

  logic [INDEX_W-1:0]   end_idx;
  logic                 looping, play;
  logic [ADDR_BITS-1:0] pos_inc;

  logic signed [SUM_W-1:0] lv_sum;
  logic [LEVEL_W-1:0]      lv_clamp;
  logic                    lv_hit;

  logic signed [SAMPLE_W-1:0] mix_r_val;
  logic signed [SAMPLE_W-1:0] out_l_val, out_r_val;

  logic signed [SAMPLE_W-1:0] out_mix_left_r, out_mix_right_r;
  logic [INDEX_W-1:0]         out_fetch_address_r;
  logic                       out_voice_done_r;

  // acc + sign(sample) * (product >> 16), saturated to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] mix_sat(
    input logic signed [SAMPLE_W-1:0] acc,
    input logic [PROD_W-1:0]          p,
    input logic                       neg
  );
    logic [OPA_W-1:0]        q;
    logic signed [OPA_W+1:0] c;
    logic signed [OPA_W+1:0] s;
    begin
      q = p[PROD_W-2:16];
      c = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      s = $signed({{(OPA_W+2-SAMPLE_W){acc[SAMPLE_W-1]}}, acc}) + c;
      if (s > $signed((OPA_W+2)'(32767)))
        mix_sat = 16'sh7fff;
      else if (s < -$signed((OPA_W+2)'(32768)))
        mix_sat = 16'sh8000;
      else
        mix_sat = s[SAMPLE_W-1:0];
    end
  endfunction

  // shared multiplier: gain * level, then each sample magnitude * factor
  assign mag_l = voice_l_r[SAMPLE_W-1] ? SAMPLE_W'(-voice_l_r) : voice_l_r;
  assign mag_r = voice_r_r[SAMPLE_W-1] ? SAMPLE_W'(-voice_r_r) : voice_r_r;

  always_comb begin
    if (cmd.mul_left) begin
      op_a = factor_r;
      op_b = {1'b0, mag_l};
    end else if (cmd.mul_right) begin
      op_a = factor_r;
      op_b = {1'b0, mag_r};
    end else begin
      op_a = {1'b0, gain_r};
      op_b = level_r;
    end
  end

  assign prod = op_a * op_b;

  // loop bounds
  assign end_idx = (loop_end_r < sample_total_r) ? loop_end_r : sample_total_r;
  assign looping = loop_enable_r && (loop_start_r < end_idx);
  assign play    = looping ? (CMP_W'(position_r) < CMP_W'(end_idx))
                           : (CMP_W'(position_r) < CMP_W'(sample_total_r));
  assign pos_inc = play ? ADDR_BITS'(position_r + 1'b1) : position_r;

  // fade step
  assign lv_sum = $signed({{(SUM_W-LEVEL_W){1'b0}}, level_r})
                + $signed({{(SUM_W-STEP_W){slope_r[STEP_W-1]}}, slope_r});

  always_comb begin
    if (lv_sum[SUM_W-1])
      lv_clamp = '0;
    else if (|lv_sum[SUM_W-2:LEVEL_W])
      lv_clamp = LEVEL_MAX;
    else
      lv_clamp = lv_sum[LEVEL_W-1:0];
    lv_hit = slope_r[STEP_W-1] ? (lv_clamp <= goal_r) : (lv_clamp >= goal_r);
  end

  assign mix_r_val = mix_sat(acc_r_r, prod_r, voice_r_r[SAMPLE_W-1]);

  always_comb begin
    position_nxt = position_r;
    finished_nxt = finished_r;
    level_nxt    = level_r;
    slope_nxt    = slope_r;
    goal_nxt     = goal_r;
    out_l_val    = acc_l_r;
    out_r_val    = acc_r_r;
    unique case (action_r)
      ACT_MIX: begin
        if (!finished_r) begin
          if (play) begin
            out_l_val = mix_l_r;
            out_r_val = mix_r_val;
          end
          if (slope_r != '0) begin
            if (lv_hit) begin
              level_nxt = goal_r;
              slope_nxt = '0;
            end else begin
              level_nxt = lv_clamp;
            end
          end
          if (looping) begin
            if (CMP_W'(pos_inc) >= CMP_W'(end_idx))
              position_nxt = ADDR_BITS'(loop_start_r);
            else
              position_nxt = pos_inc;
          end else begin
            position_nxt = pos_inc;
            if (CMP_W'(pos_inc) >= CMP_W'(sample_total_r))
              finished_nxt = 1'b1;
          end
        end
      end
      ACT_FADE: begin
        goal_nxt  = target_r;
        slope_nxt = (target_r == level_r) ? '0 : step_r;
      end
      ACT_RESTART: begin
        position_nxt = '0;
        finished_nxt = 1'b0;
        level_nxt    = LEVEL_UNITY;
        slope_nxt    = '0;
        goal_nxt     = LEVEL_UNITY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r         <= GAIN_UNITY;
      loop_start_r   <= '0;
      loop_end_r     <= '0;
      loop_enable_r  <= 1'b0;
      sample_total_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:         gain_r         <= cfg_data[GAIN_W-1:0];
        CFG_LOOP_START:   loop_start_r   <= cfg_data[INDEX_W-1:0];
        CFG_LOOP_END:     loop_end_r     <= cfg_data[INDEX_W-1:0];
        CFG_LOOP_ENABLE:  loop_enable_r  <= cfg_data[0];
        CFG_SAMPLE_TOTAL: sample_total_r <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      finished_r <= 1'b0;
      level_r    <= LEVEL_UNITY;
      slope_r    <= '0;
      goal_r     <= LEVEL_UNITY;
    end else if (cmd.wb) begin
      position_r <= position_nxt;
      finished_r <= finished_nxt;
      level_r    <= level_nxt;
      slope_r    <= slope_nxt;
      goal_r     <= goal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r  <= in_action;
      acc_l_r   <= in_acc_left;
      acc_r_r   <= in_acc_right;
      voice_l_r <= in_voice_left;
      voice_r_r <= in_voice_right;
      target_r  <= in_fade_target;
      step_r    <= in_fade_step;
      factor_r  <= prod[PROD_W-2:16];
    end
    if (cmd.mul_left || cmd.mul_right)
      prod_r <= prod;
    if (cmd.mul_right)
      mix_l_r <= mix_sat(acc_l_r, prod_r, voice_l_r[SAMPLE_W-1]);
    if (cmd.wb) begin
      out_mix_left_r      <= out_l_val;
      out_mix_right_r     <= out_r_val;
      out_fetch_address_r <= INDEX_W'(position_nxt);
      out_voice_done_r    <= finished_nxt;
    end
  end

  assign out_mix_left      = out_mix_left_r;
  assign out_mix_right     = out_mix_right_r;
  assign out_fetch_address = out_fetch_address_r;
  assign out_voice_done    = out_voice_done_r;

endmodule

FILE: hw/rtl/voice_mixer_loop_fade_unit.sv
// one voice of a 16-bit stereo mixer: each mix word adds the voice sample,
// scaled by gain times fade level, to the running left/right mix with
// saturation, steps the fade toward its goal and advances the play position,
// wrapping to loop_start when looping is valid or flagging done at the end of
// the sound; fade and restart words pass the mix through. every word passes
// through load, left multiply, right multiply and write-back: one shared
// 19 x 17 multiplier is used three times in a row (gain times level, left
// magnitude times factor, right magnitude times factor) and write-back does
// the last add, the state update and the load of the output register. the
// output register lets the next word be accepted while a result still waits
// on out_stall; write-back waits only if the previous result has not been
// taken. configuration may be written whenever no word is in flight.
module voice_mixer_loop_fade_unit
  import vmlf_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration port
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  // input word
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACTION_W-1:0]        in_action,
  input  logic signed [SAMPLE_W-1:0] in_acc_left,
  input  logic signed [SAMPLE_W-1:0] in_acc_right,
  input  logic signed [SAMPLE_W-1:0] in_voice_left,
  input  logic signed [SAMPLE_W-1:0] in_voice_right,
  input  logic [LEVEL_W-1:0]         in_fade_target,
  input  logic signed [STEP_W-1:0]   in_fade_step,
  // result word
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_mix_left,
  output logic signed [SAMPLE_W-1:0] out_mix_right,
  output logic [INDEX_W-1:0]         out_fetch_address,
  output logic                       out_voice_done
);

  vmlf_cmd_t cmd;

  // sequencer: idle, left multiply, right multiply, write-back
  vmlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // registers, voice state, shared multiplier and output register
  vmlf_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_action         (in_action),
    .in_acc_left       (in_acc_left),
    .in_acc_right      (in_acc_right),
    .in_voice_left     (in_voice_left),
    .in_voice_right    (in_voice_right),
    .in_fade_target    (in_fade_target),
    .in_fade_step      (in_fade_step),
    .out_mix_left      (out_mix_left),
    .out_mix_right     (out_mix_right),
    .out_fetch_address (out_fetch_address),
    .out_voice_done    (out_voice_done)
  );

endmodule
